/* rtl/core/olve_pkg.sv */
// Package for the ordered value list engine.
// Holds the request and result types, operation and status codes, and the
// command and status types shared by the controller and the datapath.
package olve_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int REQ_W        = 3;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 3;
    localparam int TOTAL_W      = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT_AFTER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ         = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
        logic [POS_W-1:0]         position;
    } olve_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic [TOTAL_W-1:0]       entry_total;
    } olve_rsp_t;

    // Where a new entry goes, or which entry is taken out.
    typedef enum logic [1:0] {
        AT_FRONT = 2'd0,
        AT_BACK  = 2'd1,
        AT_AFTER = 2'd2,
        AT_HIT   = 2'd3
    } olve_at_t;

    typedef struct packed {
        logic     load;
        logic     scan_init;
        logic     scan_step;
        logic     shift_init;
        olve_at_t at_sel;
        logic     shift_step;
        logic     finish;
        logic     read_issue;
        logic     read_capture;
    } olve_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic scan_hit;
        logic scan_miss;
        logic shift_idle;
    } olve_sts_t;

endpackage

/* rtl/core/olve_datapath.sv */
// Datapath of the ordered value list engine: entry memory, entry count,
// scan and shift pointers, and the comparator.
// Depends on olve_pkg for the request, command and status types.
module olve_datapath #(
    parameter int CAPACITY = olve_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  olve_pkg::olve_req_t                request,
    input  olve_pkg::olve_cmd_t                cmd,
    output olve_pkg::olve_sts_t                sts,
    output logic signed [olve_pkg::DATA_W-1:0] read_value,
    output logic [olve_pkg::TOTAL_W-1:0]       entry_total
);
    import olve_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TOT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  at_reg, at_next;
    logic [CNT_W-1:0]  wr_addr_reg, wr_addr_next;
    logic              rdv_reg, rdv_next;
    logic              dir_up_reg, dir_up_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] tgt_reg, tgt_next;
    logic [DATA_W-1:0] rval_reg, rval_next;

    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [TOT_W-1:0]  tot_ext;
    logic [CNT_W-1:0]  at_val;
    logic              scan_live;

    always_comb
    begin
        pos_ext        = CMP_W'(request.position);
        cnt_ext        = CMP_W'(count_reg);
        scan_live      = ptr_reg < count_reg;
        sts.full       = count_reg == CNT_W'(CAPACITY);
        sts.empty      = count_reg == '0;
        sts.pos_ok     = pos_ext < cnt_ext;
        sts.scan_hit   = rdv_reg && (rd_data_reg == tgt_reg);
        sts.scan_miss  = !rdv_reg && !scan_live;
        sts.shift_idle = (remain_reg == '0) && !rdv_reg;
    end

    always_comb
    begin
        unique case (cmd.at_sel)
            AT_FRONT: at_val = '0;
            AT_BACK:  at_val = count_reg;
            AT_AFTER: at_val = ptr_reg;
            AT_HIT:   at_val = ptr_reg - CNT_W'(1);
            default:  at_val = '0;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        remain_next  = remain_reg;
        at_next      = at_reg;
        wr_addr_next = wr_addr_reg;
        rdv_next     = rdv_reg;
        dir_up_next  = dir_up_reg;
        val_next     = val_reg;
        tgt_next     = tgt_reg;
        rval_next    = rval_reg;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg[IDX_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg[IDX_W-1:0];
        mem_wdata    = rd_data_reg;

        if (cmd.load)
        begin
            val_next  = request.value;
            tgt_next  = (request.req_type == REQ_INSERT_AFTER) ? request.key : request.value;
            rval_next = '0;
        end

        if (cmd.shift_init)
        begin
            at_next     = at_val;
            rdv_next    = 1'b0;
            dir_up_next = cmd.at_sel != AT_HIT;
            if (cmd.at_sel != AT_HIT)
            begin
                ptr_next    = count_reg - CNT_W'(1);
                remain_next = count_reg - at_val;
            end
            else
            begin
                ptr_next    = ptr_reg;
                remain_next = count_reg - ptr_reg;
            end
        end
        else if (cmd.scan_init)
        begin
            ptr_next = '0;
            rdv_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_live)
            begin
                mem_re   = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
                rdv_next = 1'b1;
            end
            else
            begin
                rdv_next = 1'b0;
            end
        end
        else if (cmd.shift_step)
        begin
            mem_we = rdv_reg;
            if (remain_reg != '0)
            begin
                mem_re       = 1'b1;
                wr_addr_next = dir_up_reg ? ptr_reg + CNT_W'(1) : ptr_reg - CNT_W'(1);
                ptr_next     = dir_up_reg ? ptr_reg - CNT_W'(1) : ptr_reg + CNT_W'(1);
                remain_next  = remain_reg - CNT_W'(1);
                rdv_next     = 1'b1;
            end
            else
            begin
                rdv_next = 1'b0;
            end
        end
        else if (cmd.finish)
        begin
            if (dir_up_reg)
            begin
                mem_we     = 1'b1;
                mem_waddr  = at_reg[IDX_W-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (cmd.read_issue)
        begin
            mem_re    = 1'b1;
            mem_raddr = pos_ext[IDX_W-1:0];
        end
        else if (cmd.read_capture)
        begin
            rval_next = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            remain_reg <= '0;
            rdv_reg    <= 1'b0;
            dir_up_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            remain_reg <= remain_next;
            rdv_reg    <= rdv_next;
            dir_up_reg <= dir_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg      <= at_next;
        wr_addr_reg <= wr_addr_next;
        val_reg     <= val_next;
        tgt_reg     <= tgt_next;
        rval_reg    <= rval_next;
    end

    assign tot_ext     = TOT_W'(count_reg);
    assign entry_total = tot_ext[TOTAL_W-1:0];
    assign read_value  = rval_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && dir_up_reg) |-> (count_reg != CNT_W'(CAPACITY)))
        else $error("Insert completed on a full list.");

    a_no_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !dir_up_reg) |-> (count_reg != '0))
        else $error("Remove completed on an empty list.");

    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_init && (cmd.at_sel == AT_HIT)) |-> (ptr_reg != '0 && rdv_reg))
        else $error("Remove started without a located entry.");

endmodule

/* rtl/core/olve_ctrl.sv */
// Controller of the ordered value list engine: request decode and the
// state machine that sequences scan, shift, read and result.
// Depends on olve_pkg for codes and the command and status types.
module olve_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [olve_pkg::REQ_W-1:0]     req_type,
    input  olve_pkg::olve_sts_t            sts,
    output logic                           busy,
    output logic                           done,
    output olve_pkg::olve_cmd_t            cmd,
    output logic [olve_pkg::STATUS_W-1:0]  status,
    output logic                           found
);
    import olve_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } olve_state_t;

    olve_state_t         state_reg, state_next;
    logic [REQ_W-1:0]    op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        found_next  = found_reg;
        cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    op_next     = req_type;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    state_next  = S_DONE;
                    unique case (req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (sts.full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.shift_init = 1'b1;
                                cmd.at_sel     = (req_type == REQ_PUSH_FRONT) ? AT_FRONT : AT_BACK;
                                state_next     = S_SHIFT;
                            end
                        end
                        REQ_INSERT_AFTER:
                        begin
                            if (sts.full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (sts.empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                        REQ_READ:
                        begin
                            if (sts.pos_ok)
                            begin
                                cmd.read_issue = 1'b1;
                                state_next     = S_READ;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (sts.scan_hit)
                begin
                    if (op_reg == REQ_INSERT_AFTER)
                    begin
                        cmd.shift_init = 1'b1;
                        cmd.at_sel     = AT_AFTER;
                        state_next     = S_SHIFT;
                    end
                    else if (op_reg == REQ_REMOVE)
                    begin
                        found_next     = 1'b1;
                        cmd.shift_init = 1'b1;
                        cmd.at_sel     = AT_HIT;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (sts.scan_miss)
                begin
                    if (op_reg == REQ_INSERT_AFTER)
                    begin
                        status_next    = ST_APPENDED;
                        cmd.shift_init = 1'b1;
                        cmd.at_sel     = AT_BACK;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_idle)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= REQ_PUSH_FRONT;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = state_reg == S_DONE;
    assign status = status_reg;
    assign found  = found_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not make the engine busy.");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!found_reg || status_reg == ST_OK))
        else $error("Result flags a located value with an error status.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

endmodule

/* rtl/core/ordered_value_list_engine.sv */
// Top level of the ordered value list engine.
// Depends on olve_pkg, olve_ctrl and olve_datapath.
//
//   Port group      Direction  Handshake          Payload
//   request         in         start and busy     olve_req_t
//   result          out        done, one cycle    olve_rsp_t
//
// A request is taken when start is high and busy is low; its result is on
// result for the single cycle in which done is high, and the receiver cannot
// stall it. Push back, read and requests that fail at once walk no entries.
// Scans and shifts walk the entry memory one entry a cycle; a remove shifts
// on from where its scan stopped, and an insert after shifts from the back
// of the list. Busy stays high until the cycle after done. Reset empties
// the list at once and needs no clearing pass.
module ordered_value_list_engine #(
    parameter int CAPACITY = olve_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  olve_pkg::olve_req_t request,
    output logic                done,
    output olve_pkg::olve_rsp_t result
);
    import olve_pkg::*;

    olve_cmd_t                cmd;
    olve_sts_t                sts;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic [TOTAL_W-1:0]       entry_total;

    olve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .sts      (sts),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .status   (status),
        .found    (found)
    );

    olve_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .cmd         (cmd),
        .sts         (sts),
        .read_value  (read_value),
        .entry_total (entry_total)
    );

    always_comb
    begin
        result.status      = status;
        result.found       = found;
        result.read_value  = read_value;
        result.entry_total = entry_total;
    end

endmodule

/* tb/ordered_value_list_engine_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ordered value list engine.
// Sends list requests through the start/busy port and checks every result
// against a shadow copy of the list. Depends on olve_pkg and the RTL.
module ordered_value_list_engine_test;
    import olve_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    localparam int MAX_PRINTED  = 60;

    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
    localparam logic [REQ_W-1:0] PUSH_OPS [3] = '{REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AFTER};

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_ONES = -32'sd1;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    olve_req_t request;
    logic      done;
    olve_rsp_t result;

    ordered_value_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
    int        shadow_count = 0;
    olve_rsp_t pending_results [$];
    int        sender_idle_pct = 0;
    int        mismatch_count = 0;
    int        requests_sent = 0;
    int        results_checked = 0;
    int        full_refusals = 0;
    int        longest_list = 0;
    int        cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("ordered_value_list_engine_test NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic int find_entry(input logic signed [DATA_W-1:0] v);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_entries[i] == v)
                return i;
        return shadow_count;
    endfunction

    function automatic void place_entry(input int at, input logic signed [DATA_W-1:0] v);
        for (int i = shadow_count; i > at; i--)
            shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[at] = v;
        shadow_count++;
    endfunction

    // Applies one request to the shadow list and returns the result it must give.
    function automatic olve_rsp_t model_list_request(input olve_req_t rq);
        olve_rsp_t rsp;
        int        hit;
        logic      is_full;
        rsp = '0;
        is_full = shadow_count >= LIST_DEPTH;
        case (rq.req_type)
            REQ_PUSH_FRONT:
                if (is_full)
                    rsp.status = ST_FULL;
                else
                    place_entry(0, rq.value);
            REQ_PUSH_BACK:
                if (is_full)
                    rsp.status = ST_FULL;
                else
                    place_entry(shadow_count, rq.value);
            REQ_INSERT_AFTER:
                if (is_full)
                    rsp.status = ST_FULL;
                else
                begin
                    hit = find_entry(rq.key);
                    if (hit < shadow_count)
                        place_entry(hit + 1, rq.value);
                    else
                    begin
                        place_entry(shadow_count, rq.value);
                        rsp.status = ST_APPENDED;
                    end
                end
            REQ_REMOVE:
                if (shadow_count == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    hit = find_entry(rq.value);
                    if (hit < shadow_count)
                    begin
                        for (int i = hit; i + 1 < shadow_count; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_count--;
                        rsp.found = 1'b1;
                    end
                    else
                        rsp.status = ST_MISSING;
                end
            REQ_SEARCH:
                if (find_entry(rq.value) < shadow_count)
                    rsp.found = 1'b1;
                else
                    rsp.status = ST_MISSING;
            REQ_READ:
                if (int'(rq.position) < shadow_count)
                    rsp.read_value = shadow_entries[rq.position];
                else
                    rsp.status = ST_RANGE;
            default:
                ;
        endcase
        rsp.entry_total = TOTAL_W'(shadow_count);
        return rsp;
    endfunction

    task automatic send_list_request(input olve_req_t rq);
        int        gap_cycles;
        olve_rsp_t want;
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            if ($urandom_range(3) == 0)
                gap_cycles = $urandom_range(1, 2 * LIST_DEPTH + 8);
            else
                gap_cycles = $urandom_range(1, 6);
            repeat (gap_cycles)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = model_list_request(rq);
        pending_results.push_back(want);
        requests_sent++;
        if (want.status == ST_FULL)
            full_refusals++;
        if (shadow_count > longest_list)
            longest_list = shadow_count;
    endtask

    task automatic issue_list_op(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] v,
                                 input logic signed [DATA_W-1:0] k, input logic [POS_W-1:0] pos);
        olve_req_t rq;
        rq.req_type = op;
        rq.value = v;
        rq.key = k;
        rq.position = pos;
        send_list_request(rq);
    endtask

    // Mostly values already in the list or from a small set, so that keys and
    // searches hit; the rest cover the full 32-bit range.
    function automatic logic signed [DATA_W-1:0] pick_list_value();
        int roll;
        roll = $urandom_range(99);
        if (shadow_count > 0 && roll < 45)
            return shadow_entries[$urandom_range(shadow_count - 1)];
        if (roll < 80)
        begin
            case ($urandom_range(9))
                0: return VAL_MIN;
                1: return VAL_MAX;
                default: return DATA_W'(int'($urandom_range(15)) - 8);
            endcase
        end
        return $urandom;
    endfunction

    always @(posedge clk)
    begin : check_results
        olve_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with no request waiting: %p", result));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.found !== want.found)
                    report_mismatch($sformatf("found got %b want %b",
                                              result.found, want.found));
                if (result.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %0d want %0d",
                                              result.read_value, want.read_value));
                if (result.entry_total !== want.entry_total)
                    report_mismatch($sformatf("entry_total got %0d want %0d",
                                              result.entry_total, want.entry_total));
            end
        end
    end

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        issue_list_op(REQ_REMOVE, 0, 0, 0);
        issue_list_op(REQ_SEARCH, 0, 0, 0);
        issue_list_op(REQ_READ, 0, 0, 0);
        issue_list_op(REQ_SPARE_6, VAL_ONES, VAL_ONES, '1);
        issue_list_op(REQ_SPARE_7, VAL_MIN, VAL_MAX, '1);
        issue_list_op(REQ_PUSH_FRONT, VAL_MIN, 0, 0);
        issue_list_op(REQ_PUSH_BACK, VAL_MAX, 0, 0);
        issue_list_op(REQ_INSERT_AFTER, VAL_ONES, VAL_MIN, 0);
        issue_list_op(REQ_INSERT_AFTER, 0, 12345, 0);
        issue_list_op(REQ_PUSH_FRONT, 7, 0, 0);
        issue_list_op(REQ_PUSH_BACK, 7, 0, 0);
        issue_list_op(REQ_SEARCH, VAL_MAX, 0, 0);
        issue_list_op(REQ_SEARCH, 1, 0, 0);
        issue_list_op(REQ_READ, 0, 0, 0);
        issue_list_op(REQ_READ, 0, 0, 5);
        issue_list_op(REQ_READ, 0, 0, 6);
        issue_list_op(REQ_READ, 0, 0, '1);
        issue_list_op(REQ_REMOVE, 7, 0, 0);
        issue_list_op(REQ_READ, 0, 0, 0);
        issue_list_op(REQ_REMOVE, 7, 0, 0);
        issue_list_op(REQ_REMOVE, 999, 0, 0);
        issue_list_op(REQ_REMOVE, VAL_MIN, 0, 0);
        issue_list_op(REQ_REMOVE, 0, 0, 0);
        issue_list_op(REQ_REMOVE, VAL_ONES, 0, 0);
        issue_list_op(REQ_REMOVE, VAL_MAX, 0, 0);
    endtask

    task automatic test_fill_and_drain(input int idle_pct);
        olve_req_t rq;
        sender_idle_pct = idle_pct;
        while (shadow_count < LIST_DEPTH)
        begin
            rq.req_type = PUSH_OPS[$urandom_range(2)];
            rq.value = pick_list_value();
            rq.key = pick_list_value();
            rq.position = POS_W'($urandom_range(63));
            send_list_request(rq);
        end
        issue_list_op(REQ_PUSH_FRONT, pick_list_value(), 0, 0);
        issue_list_op(REQ_PUSH_BACK, pick_list_value(), 0, 0);
        issue_list_op(REQ_INSERT_AFTER, pick_list_value(), shadow_entries[0], 0);
        issue_list_op(REQ_INSERT_AFTER, pick_list_value(), $urandom, 0);
        issue_list_op(REQ_READ, 0, 0, '1);
        issue_list_op(REQ_SEARCH, shadow_entries[LIST_DEPTH - 1], 0, 0);
        while (shadow_count > 0)
        begin
            if ($urandom_range(5) == 0)
                issue_list_op(REQ_REMOVE, pick_list_value(), 0, 0);
            else
                issue_list_op(REQ_REMOVE, shadow_entries[$urandom_range(shadow_count - 1)], 0, 0);
        end
        issue_list_op(REQ_REMOVE, pick_list_value(), 0, 0);
        issue_list_op(REQ_READ, 0, 0, 0);
    endtask

    task automatic test_random_mix(input int items, input int idle_pct);
        olve_req_t rq;
        int        roll;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < items; n++)
        begin
            rq.value = pick_list_value();
            rq.key = pick_list_value();
            rq.position = POS_W'($urandom_range(63));
            roll = $urandom_range(99);
            if (roll < 42)
                rq.req_type = PUSH_OPS[roll % 3];
            else if (roll < 64)
                rq.req_type = REQ_REMOVE;
            else if (roll < 80)
                rq.req_type = REQ_SEARCH;
            else if (roll < 96)
                rq.req_type = REQ_READ;
            else if (roll < 98)
                rq.req_type = REQ_SPARE_6;
            else
                rq.req_type = REQ_SPARE_7;
            if (rq.req_type == REQ_READ && shadow_count > 0 && $urandom_range(3) != 0)
                rq.position = POS_W'($urandom_range(shadow_count - 1));
            send_list_request(rq);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_drain(0);
        test_random_mix(350, 0);
        test_random_mix(350, 77);
        test_fill_and_drain(77);
        test_random_mix(350, 24);
        test_random_mix(200, 0);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests of every kind and checked %0d results in %0d cycles.",
                 requests_sent, results_checked, cycle_count);
        $display("The list grew to %0d entries and refused %0d pushes while full; %0d mismatches.",
                 longest_list, full_refusals, mismatch_count);
        if (mismatch_count == 0)
            $display("ordered_value_list_engine_test OK");
        else
            $display("ordered_value_list_engine_test NOT OK");
        $finish;
    end

endmodule
